// ===== hw/rtl/cmps_pkg.sv =====
// Shared constants, types and control store for the chunky mask pixel splitter.
`timescale 1ns / 1ps

package cmps_pkg;

  localparam int unsigned MaxColorsDef    = 8;
  localparam int unsigned MaxRowPixelsDef = 65535;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned SampleW  = 12;
  localparam int unsigned BpsW     = 4;
  localparam int unsigned ColorW   = 4;
  localparam int unsigned RowW     = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned FillW    = 3;
  localparam int unsigned BitCntW  = 4;
  localparam int unsigned KW       = 4;
  localparam int unsigned NW       = 3;
  localparam int unsigned PcW      = 4;

  localparam logic [NW-1:0]       ResultLimit = NW'(4);
  localparam logic [BitCntW-1:0]  BitsPerByte = BitCntW'(ByteW);
  localparam logic [FillW-1:0]    FillFull    = FillW'(7);

  localparam logic [BpsW-1:0] BpsReset    = BpsW'(8);
  localparam logic [ColorW-1:0] ColorReset = ColorW'(3);
  localparam logic [RowW-1:0] RowReset    = RowW'(1);

  localparam logic [CfgIdxW-1:0] RegBps    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegColors = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegRow    = CfgIdxW'(2);

  localparam logic [PcW-1:0] PcWait  = PcW'(0);
  localparam logic [PcW-1:0] PcBit   = PcW'(1);
  localparam logic [PcW-1:0] PcTake  = PcW'(2);
  localparam logic [PcW-1:0] PcMask  = PcW'(3);
  localparam logic [PcW-1:0] PcPix   = PcW'(4);
  localparam logic [PcW-1:0] PcAdv   = PcW'(5);
  localparam logic [PcW-1:0] PcCheck = PcW'(6);
  localparam logic [PcW-1:0] PcFin   = PcW'(7);
  localparam logic [PcW-1:0] PcFlm   = PcW'(8);
  localparam logic [PcW-1:0] PcFlp   = PcW'(9);
  localparam logic [PcW-1:0] PcClr   = PcW'(10);

  typedef enum logic [3:0] {
    OpNop,
    OpWait,
    OpBit,
    OpTake,
    OpMask,
    OpPix,
    OpAdv,
    OpFinish,
    OpFlushMask,
    OpFlushPix,
    OpClear
  } op_e;

  typedef enum logic [2:0] {
    CondAlways,
    CondNever,
    CondNoStart,
    CondNotFull,
    CondColor,
    CondKMore,
    CondRowDone,
    CondBitsLeft
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ctrl_rom(input logic [PcW-1:0] pc);
    ctrl_t w;
    w = '{op: OpNop, cond: CondAlways, target: PcWait};
    case (pc)
      PcWait:  w = '{op: OpWait,      cond: CondNoStart,  target: PcWait};
      PcBit:   w = '{op: OpBit,       cond: CondNotFull,  target: PcCheck};
      PcTake:  w = '{op: OpTake,      cond: CondColor,    target: PcPix};
      PcMask:  w = '{op: OpMask,      cond: CondAlways,   target: PcAdv};
      PcPix:   w = '{op: OpPix,       cond: CondKMore,    target: PcPix};
      PcAdv:   w = '{op: OpAdv,       cond: CondRowDone,  target: PcFlm};
      PcCheck: w = '{op: OpNop,       cond: CondBitsLeft, target: PcBit};
      PcFin:   w = '{op: OpFinish,    cond: CondAlways,   target: PcWait};
      PcFlm:   w = '{op: OpFlushMask, cond: CondNever,    target: PcWait};
      PcFlp:   w = '{op: OpFlushPix,  cond: CondNever,    target: PcWait};
      PcClr:   w = '{op: OpClear,     cond: CondAlways,   target: PcFin};
      default: w = '{op: OpNop,       cond: CondAlways,   target: PcWait};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/cmps_if.sv =====
// Channel interfaces: source bytes in, plane bytes out, register writes.
`timescale 1ns / 1ps

interface cmps_in_if import cmps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink   (input valid, input src_byte, output ready);
endinterface

interface cmps_out_if import cmps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             plane_sel;
  logic [ByteW-1:0] out_byte;
  logic             row_end;
  logic             last;

  modport source (output valid, output plane_sel, output out_byte, output row_end,
                  output last, input ready);
  modport sink   (input valid, input plane_sel, input out_byte, input row_end,
                  input last, output ready);
endinterface

interface cmps_cfg_if import cmps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_idx;
  logic [CfgDataW-1:0] reg_data;

  modport source (output valid, output reg_idx, output reg_data, input ready);
  modport sink   (input valid, input reg_idx, input reg_data, output ready);
endinterface

// ===== hw/rtl/chunky_mask_pixel_splitter_top.sv =====
// Chunky mask plus colour splitter: microcoded bit sequencer with output register.
// Steps: fetch; per bit shift and check; per mask sample take, mask, advance; per colour
// sample take, a pixel step per sample bit, advance; finish. A row end swaps the check for
// mask flush, pixel flush and clear and drops later bits. Bytes are taken only at fetch; an
// invalid width drops them. A full output register with ready low stalls a pending-byte push.
// Reset: registers return to 8 bits per sample, 3 colours, 1 pixel per row; row state clears.
`timescale 1ns / 1ps

module chunky_mask_pixel_splitter_top import cmps_pkg::*; #(
  parameter int unsigned MAX_COLORS     = MaxColorsDef,
  parameter int unsigned MAX_ROW_PIXELS = MaxRowPixelsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmps_in_if.sink    src_i,
  cmps_out_if.source res_o,
  cmps_cfg_if.sink   cfg_i
);

  localparam int unsigned CW  = $clog2(MAX_COLORS + 1);
  localparam int unsigned PCW = $clog2(MAX_ROW_PIXELS + 1);
  localparam logic [ColorW:0] MaxColorsW = (ColorW + 1)'(MAX_COLORS);
  localparam logic [RowW-1:0] MaxRowW    = RowW'(MAX_ROW_PIXELS);

  logic [BpsW-1:0]    bps_q;
  logic [ColorW-1:0]  colors_q;
  logic [RowW-1:0]    rowlen_q;

  logic [PcW-1:0]     pc_q, pc_d;
  logic [ByteW-1:0]   src_q, src_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [SampleW-1:0] acc_q, acc_d;
  logic [BpsW-1:0]    held_q, held_d;
  logic [SampleW-1:0] val_q, val_d;
  logic [KW-1:0]      k_q, k_d;
  logic [CW-1:0]      comp_q, comp_d;
  logic [PCW-1:0]     pix_cnt_q, pix_cnt_d;
  logic [ByteW-1:0]   mask_acc_q, mask_acc_d;
  logic [FillW-1:0]   mask_fill_q, mask_fill_d;
  logic [ByteW-1:0]   pix_acc_q, pix_acc_d;
  logic [FillW-1:0]   pix_fill_q, pix_fill_d;
  logic               row_done_q, row_done_d;
  logic [NW-1:0]      n_q, n_d;

  logic               pend_v_q, pend_v_d;
  logic               pend_plane_q, pend_plane_d;
  logic [ByteW-1:0]   pend_byte_q, pend_byte_d;

  logic               out_v_q, out_v_d;
  logic               out_plane_q, out_plane_d;
  logic [ByteW-1:0]   out_byte_q, out_byte_d;
  logic               out_row_end_q, out_row_end_d;
  logic               out_last_q, out_last_d;

  ctrl_t              ctrl;
  logic               bps_ok;
  logic [CW-1:0]      colors_eff;
  logic [RowW-1:0]    rowlen_eff;
  logic               adv_wrap;
  logic               adv_done;
  logic               cond_hit;
  logic               emit_req;
  logic               emit_plane;
  logic [ByteW-1:0]   emit_byte;
  logic               do_emit;
  logic               push_req;
  logic               push_last;
  logic               stall;
  logic [ByteW-1:0]   mask_next;
  logic [ByteW-1:0]   pix_next;
  logic               src_fire;

  assign ctrl     = ctrl_rom(pc_q);
  assign src_fire = src_i.valid & src_i.ready;

  assign src_i.ready     = (pc_q == PcWait);
  assign cfg_i.ready     = 1'b1;
  assign res_o.valid     = out_v_q;
  assign res_o.plane_sel = out_plane_q;
  assign res_o.out_byte  = out_byte_q;
  assign res_o.row_end   = out_row_end_q;
  assign res_o.last      = out_last_q;

  always_comb begin
    bps_ok = bps_q inside {4'd1, 4'd2, 4'd4, 4'd8, 4'd12};
    if (colors_q == '0) begin
      colors_eff = CW'(1);
    end else if ({1'b0, colors_q} > MaxColorsW) begin
      colors_eff = CW'(MAX_COLORS);
    end else begin
      colors_eff = CW'(colors_q);
    end
    if (rowlen_q == '0) begin
      rowlen_eff = RowW'(1);
    end else if (rowlen_q > MaxRowW) begin
      rowlen_eff = MaxRowW;
    end else begin
      rowlen_eff = rowlen_q;
    end
  end

  assign adv_wrap  = ({1'b0, comp_q} + (CW + 1)'(1)) > {1'b0, colors_eff};
  assign adv_done  = adv_wrap &&
                     ((RowW + 1)'(pix_cnt_q) + (RowW + 1)'(1)) >= {1'b0, rowlen_eff};
  assign mask_next = {mask_acc_q[ByteW-2:0], |val_q};
  assign pix_next  = {pix_acc_q[ByteW-2:0], val_q[k_q]};

  always_comb begin
    case (ctrl.cond)
      CondAlways:   cond_hit = 1'b1;
      CondNever:    cond_hit = 1'b0;
      CondNoStart:  cond_hit = !(src_i.valid && bps_ok);
      CondNotFull:  cond_hit = ({1'b0, held_q} + (BpsW + 1)'(1)) < {1'b0, bps_q};
      CondColor:    cond_hit = (comp_q != '0);
      CondKMore:    cond_hit = (k_q != '0);
      CondRowDone:  cond_hit = adv_done;
      CondBitsLeft: cond_hit = (bit_cnt_q != '0);
      default:      cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    emit_req   = 1'b0;
    emit_plane = 1'b0;
    emit_byte  = '0;
    case (ctrl.op)
      OpMask: begin
        emit_req  = (mask_fill_q == FillFull);
        emit_byte = mask_next;
      end
      OpPix: begin
        emit_req   = (pix_fill_q == FillFull);
        emit_plane = 1'b1;
        emit_byte  = pix_next;
      end
      OpFlushMask: begin
        emit_req  = (mask_fill_q != '0);
        emit_byte = mask_acc_q << (4'd8 - {1'b0, mask_fill_q});
      end
      OpFlushPix: begin
        emit_req   = (pix_fill_q != '0);
        emit_plane = 1'b1;
        emit_byte  = pix_acc_q << (4'd8 - {1'b0, pix_fill_q});
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
  end

  assign do_emit   = emit_req && (n_q < ResultLimit);
  assign push_last = (ctrl.op == OpFinish);
  assign push_req  = pend_v_q && (do_emit || push_last);
  assign stall     = push_req && out_v_q && !res_o.ready;

  always_comb begin
    pc_d          = pc_q;
    src_d         = src_q;
    bit_cnt_d     = bit_cnt_q;
    acc_d         = acc_q;
    held_d        = held_q;
    val_d         = val_q;
    k_d           = k_q;
    comp_d        = comp_q;
    pix_cnt_d     = pix_cnt_q;
    mask_acc_d    = mask_acc_q;
    mask_fill_d   = mask_fill_q;
    pix_acc_d     = pix_acc_q;
    pix_fill_d    = pix_fill_q;
    row_done_d    = row_done_q;
    n_d           = n_q;
    pend_v_d      = pend_v_q;
    pend_plane_d  = pend_plane_q;
    pend_byte_d   = pend_byte_q;
    out_v_d       = out_v_q && !res_o.ready;
    out_plane_d   = out_plane_q;
    out_byte_d    = out_byte_q;
    out_row_end_d = out_row_end_q;
    out_last_d    = out_last_q;

    if (!stall) begin
      pc_d = cond_hit ? ctrl.target : pc_q + PcW'(1);

      if (push_req) begin
        out_v_d       = 1'b1;
        out_plane_d   = pend_plane_q;
        out_byte_d    = pend_byte_q;
        out_last_d    = push_last;
        out_row_end_d = push_last && row_done_q;
        pend_v_d      = 1'b0;
      end
      if (do_emit) begin
        pend_v_d     = 1'b1;
        pend_plane_d = emit_plane;
        pend_byte_d  = emit_byte;
        n_d          = n_q + NW'(1);
      end

      case (ctrl.op)
        OpWait: begin
          if (src_fire && bps_ok) begin
            src_d     = src_i.src_byte;
            bit_cnt_d = BitsPerByte;
            n_d       = '0;
          end
        end
        OpBit: begin
          acc_d     = {acc_q[SampleW-2:0], src_q[ByteW-1]};
          src_d     = {src_q[ByteW-2:0], 1'b0};
          held_d    = held_q + BpsW'(1);
          bit_cnt_d = bit_cnt_q - BitCntW'(1);
        end
        OpTake: begin
          val_d  = acc_q;
          acc_d  = '0;
          held_d = '0;
          k_d    = KW'(bps_q) - KW'(1);
        end
        OpMask: begin
          if (mask_fill_q == FillFull) begin
            mask_acc_d  = '0;
            mask_fill_d = '0;
          end else begin
            mask_acc_d  = mask_next;
            mask_fill_d = mask_fill_q + FillW'(1);
          end
        end
        OpPix: begin
          if (pix_fill_q == FillFull) begin
            pix_acc_d  = '0;
            pix_fill_d = '0;
          end else begin
            pix_acc_d  = pix_next;
            pix_fill_d = pix_fill_q + FillW'(1);
          end
          k_d = k_q - KW'(1);
        end
        OpAdv: begin
          if (adv_wrap) begin
            comp_d     = '0;
            pix_cnt_d  = pix_cnt_q + PCW'(1);
            row_done_d = adv_done;
          end else begin
            comp_d = comp_q + CW'(1);
          end
        end
        OpClear: begin
          acc_d       = '0;
          held_d      = '0;
          comp_d      = '0;
          pix_cnt_d   = '0;
          mask_acc_d  = '0;
          mask_fill_d = '0;
          pix_acc_d   = '0;
          pix_fill_d  = '0;
        end
        OpFinish: begin
          row_done_d = 1'b0;
        end
        default: begin
          row_done_d = row_done_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q    <= BpsReset;
      colors_q <= ColorReset;
      rowlen_q <= RowReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.reg_idx)
        RegBps:    bps_q    <= cfg_i.reg_data[BpsW-1:0];
        RegColors: colors_q <= cfg_i.reg_data[ColorW-1:0];
        RegRow:    rowlen_q <= cfg_i.reg_data[RowW-1:0];
        default:   bps_q    <= bps_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcWait;
      bit_cnt_q   <= '0;
      acc_q       <= '0;
      held_q      <= '0;
      k_q         <= '0;
      comp_q      <= '0;
      pix_cnt_q   <= '0;
      mask_acc_q  <= '0;
      mask_fill_q <= '0;
      pix_acc_q   <= '0;
      pix_fill_q  <= '0;
      row_done_q  <= 1'b0;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      bit_cnt_q   <= bit_cnt_d;
      acc_q       <= acc_d;
      held_q      <= held_d;
      k_q         <= k_d;
      comp_q      <= comp_d;
      pix_cnt_q   <= pix_cnt_d;
      mask_acc_q  <= mask_acc_d;
      mask_fill_q <= mask_fill_d;
      pix_acc_q   <= pix_acc_d;
      pix_fill_q  <= pix_fill_d;
      row_done_q  <= row_done_d;
      n_q         <= n_d;
      pend_v_q    <= pend_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q         <= src_d;
    val_q         <= val_d;
    pend_plane_q  <= pend_plane_d;
    pend_byte_q   <= pend_byte_d;
    out_plane_q   <= out_plane_d;
    out_byte_q    <= out_byte_d;
    out_row_end_q <= out_row_end_d;
    out_last_q    <= out_last_d;
  end

  a_no_pend_at_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PcWait) |-> !pend_v_q)
    else $error("pending transfer left over at byte fetch");

  a_result_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= ResultLimit)
    else $error("result count exceeds limit");

  a_clear_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PcClr) |=> (pix_cnt_q == '0 && mask_fill_q == '0 && pix_fill_q == '0
                         && comp_q == '0 && pc_q == PcFin))
    else $error("row state not cleared at row end");

  a_row_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_row_end_q) |-> out_last_q)
    else $error("row end transfer not marked last");

endmodule
